// File: sv/rcgr_pkg.sv
// ----------------------------------------------------------------------------
// rcgr_pkg
// Shared widths and status codes for the ray combination gcd reducer.
// ----------------------------------------------------------------------------
package rcgr_pkg;
  localparam int CoordW = 12;
  localparam int DistW  = 14;
  localparam int CombW  = 26;
  localparam int MagW   = 25;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_WRONG_SIG = 2'd1,
    ST_ALL_ZERO  = 2'd2
  } status_t;
endpackage

// File: sv/ray_combine_gcd_reduce.sv
// ----------------------------------------------------------------------------
// ray_combine_gcd_reduce
// Buffers coordinate pairs of two rays and combines them on the last pair.
// The combined vector is then reduced by the gcd of its coordinates.
// A non-last word is only buffered. A last word combines each buffered pair
// (read, multiply, write), folds each coordinate into the gcd by Euclid
// remainder steps, then divides each coordinate by the gcd for output.
// Reset clears control state only; the ray memories are not cleared.
// ----------------------------------------------------------------------------
module ray_combine_gcd_reduce
  import rcgr_pkg::*;
#(
  parameter int RAY_DIM = 63
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CoordW-1:0] pos_coord,
  input  logic signed [CoordW-1:0] neg_coord,
  input  logic signed [DistW-1:0]  pos_distance,
  input  logic signed [DistW-1:0]  neg_distance,
  input  logic                     last_pair,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CombW-1:0]  coord_out,
  output logic                     last_out,
  output logic [1:0]               status
);

  localparam int IdxW = $clog2(RAY_DIM);
  localparam int CntW = $clog2(RAY_DIM + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_CRD, S_CMUL, S_CWR, S_GRD, S_GCHK, S_MOD, S_DRD, S_DIV, S_OUT
  } state_t;

  // Memories: raw rays and the combined vector.
  logic [2*CoordW-1:0] ray_mem [RAY_DIM];
  logic [CombW-1:0]    comb_mem [RAY_DIM];
  logic [2*CoordW-1:0] ray_rd;
  logic [CombW-1:0]    comb_rd;

  state_t                  state;
  logic [CntW-1:0]         coord_count;
  logic [CntW-1:0]         n;
  logic [CntW-1:0]         idx;
  logic signed [DistW:0]   pd;
  logic signed [DistW:0]   nd;
  logic signed [CombW-1:0] prod_a;
  logic signed [CombW-1:0] prod_b;
  logic [MagW-1:0]         running_gcd;
  // Shared restoring divider: quotient/dividend in dq, remainder in rem.
  logic [MagW-1:0]         dq;
  logic [MagW:0]           rem;
  logic [MagW-1:0]         dvs;
  logic [4:0]              step;
  logic                    neg_q;
  logic                    any_nz;

  logic [MagW:0] trial;
  logic [MagW:0] rem_sh;
  logic          accept;
  logic [MagW-1:0] comb_mag;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_LOAD);
  assign rem_sh   = {rem[MagW-1:0], dq[MagW-1]};
  assign trial    = rem_sh - {1'b0, dvs};
  assign comb_mag = comb_rd[CombW-1] ? MagW'(-comb_rd) : comb_rd[MagW-1:0];

  always_ff @(posedge clk) begin
    if (accept && coord_count < CntW'(RAY_DIM)) begin
      ray_mem[coord_count[IdxW-1:0]] <= {pos_coord, neg_coord};
    end
    ray_rd <= ray_mem[idx[IdxW-1:0]];
    if (state == S_CWR) begin
      comb_mem[idx[IdxW-1:0]] <= CombW'(prod_a + prod_b);
    end
    comb_rd <= comb_mem[idx[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      coord_count <= '0;
      out_valid   <= 1'b0;
      idx         <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (last_pair) begin
              n  <= (coord_count < CntW'(RAY_DIM)) ? coord_count + 1'b1 : coord_count;
              coord_count <= '0;
              pd <= (DistW+1)'(pos_distance);
              nd <= -(DistW+1)'(neg_distance);
              idx <= '0;
              any_nz <= 1'b0;
              running_gcd <= '0;
              if (pos_distance <= 0 || neg_distance >= 0) begin
                coord_out <= '0;
                last_out  <= 1'b1;
                status    <= ST_WRONG_SIG;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end else begin
                state <= S_CRD;
              end
            end else if (coord_count < CntW'(RAY_DIM)) begin
              coord_count <= coord_count + 1'b1;
            end
          end
        end
        S_CRD: state <= S_CMUL;
        S_CMUL: begin
          // Multiply against the registered read word.
          prod_a <= CombW'(nd) * CombW'($signed(ray_rd[2*CoordW-1:CoordW]));
          prod_b <= CombW'(pd) * CombW'($signed(ray_rd[CoordW-1:0]));
          state  <= S_CWR;
        end
        S_CWR: begin
          if (idx + 1'b1 == n) begin
            idx   <= '0;
            state <= S_GRD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_CRD;
          end
        end
        S_GRD: state <= S_GCHK;
        S_GCHK: begin
          // Fold one coordinate into the running gcd.
          if (running_gcd == MagW'(1)) begin
            idx <= '0;
            state <= S_DRD;
          end else if (comb_mag == '0) begin
            if (idx + 1'b1 == n) begin
              idx <= '0;
              state <= S_DRD;
            end else begin
              idx <= idx + 1'b1;
              state <= S_GRD;
            end
          end else if (running_gcd == '0) begin
            running_gcd <= comb_mag;
            if (idx + 1'b1 == n) begin
              idx <= '0;
              state <= S_DRD;
            end else begin
              idx <= idx + 1'b1;
              state <= S_GRD;
            end
          end else begin
            dq <= running_gcd;
            dvs <= comb_mag;
            rem <= '0;
            step <= '0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (step == 5'(MagW - 1)) begin
            if (trial[MagW] ? (rem_sh == '0) : (trial == '0)) begin
              running_gcd <= dvs;
              if (idx + 1'b1 == n) begin
                idx <= '0;
                state <= S_DRD;
              end else begin
                idx <= idx + 1'b1;
                state <= S_GRD;
              end
            end else begin
              dq <= dvs;
              dvs <= trial[MagW] ? rem_sh[MagW-1:0] : trial[MagW-1:0];
              rem <= '0;
              step <= '0;
            end
          end else begin
            if (trial[MagW]) rem <= rem_sh;
            else rem <= trial;
            dq <= {dq[MagW-2:0], ~trial[MagW]};
            step <= step + 1'b1;
          end
        end
        S_DRD: begin
          if (running_gcd == '0) begin
            coord_out <= '0;
            last_out <= 1'b1;
            status <= ST_ALL_ZERO;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (any_nz) begin
            // Read data now valid: start exact division.
            dq <= comb_mag;
            neg_q <= comb_rd[CombW-1];
            dvs <= running_gcd;
            rem <= '0;
            step <= '0;
            state <= S_DIV;
          end else begin
            any_nz <= 1'b1;
          end
        end
        S_DIV: begin
          if (trial[MagW]) rem <= rem_sh;
          else rem <= trial;
          dq <= {dq[MagW-2:0], ~trial[MagW]};
          step <= step + 1'b1;
          if (step == 5'(MagW - 1)) begin
            coord_out <= neg_q ? -CombW'({dq[MagW-2:0], ~trial[MagW]})
                               : CombW'({dq[MagW-2:0], ~trial[MagW]});
            last_out <= (idx + 1'b1 == n);
            status <= ST_OK;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_out) begin
              state <= S_LOAD;
            end else begin
              idx <= idx + 1'b1;
              any_nz <= 1'b0;
              state <= S_DRD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray combination gcd reducer. Rays are sent
// pair by pair; a behavioural predictor forms the combined, gcd-reduced
// vector and every result word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import rcgr_pkg::*;

  localparam int RayDim   = 63;
  localparam int WdogMax  = 200000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [CoordW-1:0] pos_coord;
  logic signed [CoordW-1:0] neg_coord;
  logic signed [DistW-1:0]  pos_distance;
  logic signed [DistW-1:0]  neg_distance;
  logic last_pair;
  logic out_valid;
  logic out_stall;
  logic signed [CombW-1:0] coord_out;
  logic last_out;
  logic [1:0] status;

  // One expected result word.
  typedef struct packed {
    logic signed [CombW-1:0] coord;
    logic                    last;
    status_t                 st;
  } ray_word_t;

  ray_word_t reduced_q[$];

  // Predictor state: pairs buffered for the ray in progress.
  int pos_buf[RayDim];
  int neg_buf[RayDim];
  int pair_count;

  int errors = 0;
  int words_sent;
  int words_seen = 0;
  int rays_done;
  int idle_pct;
  int wdog = 0;

  ray_combine_gcd_reduce #(.RAY_DIM(RayDim)) u_top (
    .clk, .rst, .in_valid, .in_stall, .pos_coord, .neg_coord,
    .pos_distance, .neg_distance, .last_pair,
    .out_valid, .out_stall, .coord_out, .last_out, .status
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int mag(int x);
    return x < 0 ? -x : x;
  endfunction

  // Predict the words one accepted pair causes.
  function automatic void predict_pair(int pc, int nc, int pd, int nd, bit lp);
    int comb[RayDim];
    int n;
    int g;
    int a;
    int b;
    int t;
    ray_word_t w;
    if (pair_count < RayDim) begin
      pos_buf[pair_count] = pc;
      neg_buf[pair_count] = nc;
      pair_count++;
    end
    if (!lp) return;
    n = pair_count;
    pair_count = 0;
    if (pd <= 0 || -nd <= 0) begin
      w.coord = '0; w.last = 1'b1; w.st = ST_WRONG_SIG;
      reduced_q.push_back(w);
      return;
    end
    for (int i = 0; i < n; i++) comb[i] = (-nd) * pos_buf[i] + pd * neg_buf[i];
    g = mag(comb[0]);
    for (int i = 1; g != 1 && i < n; i++) begin
      a = g;
      b = mag(comb[i]);
      while (b != 0) begin
        t = a % b; a = b; b = t;
      end
      g = a;
    end
    if (g <= 0) begin
      w.coord = '0; w.last = 1'b1; w.st = ST_ALL_ZERO;
      reduced_q.push_back(w);
      return;
    end
    for (int i = 0; i < n; i++) begin
      w.coord = CombW'(comb[i] / g);
      w.last  = (i + 1 == n);
      w.st    = ST_OK;
      reduced_q.push_back(w);
    end
  endfunction

  // Send one word; hold it until the block takes it. Valid stays high
  // afterwards until the next word or an idle cycle replaces it.
  task automatic send_pair(int pc, int nc, int pd, int nd, bit lp);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    pos_coord    <= CoordW'(pc);
    neg_coord    <= CoordW'(nc);
    pos_distance <= DistW'(pd);
    neg_distance <= DistW'(nd);
    last_pair    <= lp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pair(pc, nc, pd, nd, lp);
    words_sent++;
    if (lp) rays_done++;
  endtask

  // Send a whole ray of n pairs with given distances; coordinates are
  // drawn from -span to span.
  task automatic send_ray(int n, int pd, int nd, int span);
    for (int i = 0; i < n; i++)
      send_pair($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                pd, nd, i == n - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_extremes();
    // Corner values of every field, short rays.
    send_pair(-1700, 1700, 8191, -8191, 1'b0);
    send_pair(1700, -1700, 8191, -8191, 1'b1);
    send_pair(-2048, 2047, 8191, -8192, 1'b1);  // full 12 and 14 bit extremes
    send_pair(2047, -2048, 1, -1, 1'b0);
    send_pair(-1, 0, 1, -1, 1'b1);
    // Distances: only the last word's count.
    send_pair(4, 6, -5, 3, 1'b0);
    send_pair(2, 8, 3, -2, 1'b1);
  endtask

  task automatic test_errors();
    send_pair(5, 7, 0, -3, 1'b1);       // zero positive distance
    send_pair(5, 7, 3, 0, 1'b1);        // zero negative distance
    send_pair(5, 7, -8192, 8191, 1'b1); // both signs wrong
    send_pair(0, 0, 3, -3, 1'b0);
    send_pair(0, 0, 3, -3, 1'b1);       // combined vector all zero
    send_pair(3, 3, 2, -2, 1'b1);       // single coordinate reduces to one
    send_pair(10, 20, 4, -6, 1'b1);     // single coordinate reduces to sign
  endtask

  task automatic test_overflow();
    // More pairs than the buffer holds: extras, last one included, drop.
    for (int i = 0; i < RayDim + 3; i++)
      send_pair($urandom_range(3400) - 1700, $urandom_range(3400) - 1700,
                $urandom_range(8191, 1), -$urandom_range(8191, 1), i == RayDim + 2);
  endtask

  task automatic test_random(int count);
    int sent;
    int n;
    int span;
    int pd;
    int nd;
    sent = 0;
    while (sent < count) begin
      n    = ($urandom_range(9) == 0) ? $urandom_range(RayDim, 20) : $urandom_range(6, 1);
      span = ($urandom_range(3) == 0) ? 3 : 1700;
      pd   = $urandom_range(8191, 1);
      nd   = -$urandom_range(8191, 1);
      if ($urandom_range(9) == 0) pd = $urandom_range(8192) - 8192;
      if ($urandom_range(9) == 0) nd = $urandom_range(8191);
      if ($urandom_range(3) == 0) begin
        pd = $urandom_range(4, 1) * 6; nd = -$urandom_range(4, 1) * 6;
      end
      send_ray(n, pd, nd, span);
      sent += n;
    end
  endtask

  // Result checker: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin
    ray_word_t w;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (reduced_q.size() == 0) begin
        $error("unexpected word: coord_out %0d last_out %0b status %0d",
               coord_out, last_out, status);
        errors++;
      end else begin
        w = reduced_q.pop_front();
        if (coord_out !== w.coord) begin
          $error("coord_out: expected %0d, got %0d", w.coord, coord_out);
          errors++;
        end
        if (last_out !== w.last) begin
          $error("last_out: expected %0b, got %0b", w.last, last_out);
          errors++;
        end
        if (status !== w.st) begin
          $error("status: expected %0d, got %0d", w.st, status);
          errors++;
        end
      end
    end
  end

  // Output stall: random, same rate as the sender.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WdogMax) begin
      $display("timeout after %0d idle cycles", wdog);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    words_sent = 0; rays_done = 0;
    pair_count = 0; idle_pct = 8;
    rst = 1'b1; in_valid = 1'b0;
    pos_coord = '0; neg_coord = '0; pos_distance = '0; neg_distance = '0;
    last_pair = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_errors();
    drain();            // hold the sender until every word is back
    test_overflow();
    test_random(30);
    idle_pct = 0;       // long stretch with no idling
    test_random(20);
    idle_pct = 8;
    test_random(25);
    drain();
    repeat (200) @(posedge clk);
    $display("sent %0d pairs in %0d rays, checked %0d result words",
             words_sent, rays_done, words_seen);
    $display("covered extremes, sign and zero errors, buffer overflow, gcd reduction");
    if (errors == 0 && reduced_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
